// ----- src/lbp_pkg.sv -----
// Shared types, constants and the uniform-pattern lookup table for the LBP pixel coder.
// Used by lbp_code_unit, lbp_out_fifo and lbp_3x3_pixel_coder. No dependencies.
package lbp_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WIDTH_W   = 11;
  localparam int HEIGHT_W  = 16;
  localparam int PIX_W     = 8;
  localparam int MIN_DIM   = 3;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = OUT_PTR_W + 1;

  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_UNIFORM_MODE = 2'd2;

  localparam logic [PIX_W-1:0] UNIFORM_MAX = 8'd58;

  typedef struct packed {
    logic valid;
    logic emit;
    logic last;
  } s1_ctrl_t;

  typedef struct packed {
    logic [PIX_W-1:0] code;
    logic             frame_last;
  } result_t;

  typedef logic [PIX_W-1:0] lut_t [256];

  // index 1..58 for patterns with at most two non-circular transitions, else 0
  function automatic lut_t build_uniform_lut();
    lut_t       lut;
    logic [7:0] t;
    int         next_idx;
    next_idx = 1;
    for (int p = 0; p < 256; p++) begin
      t = 8'(p) ^ (8'(p) >> 1);
      t[7] = 1'b0;
      if ($countones(t) <= 2) begin
        lut[p] = 8'(next_idx);
        next_idx++;
      end else begin
        lut[p] = '0;
      end
    end
    return lut;
  endfunction

  localparam lut_t UNIFORM_LUT = build_uniform_lut();

endpackage

// ----- src/lbp_3x3_pixel_coder.sv -----
// LBP 3x3 pixel coder top: APB registers, raster counters, line store RAM.
// A result passes the s1 stage, the window stage and the result queue before it is offered.
// Throughput: one pixel per cycle while pixel_ready is high; the line store RAM does one read and one write per cycle.
// pixel_ready drops while result queue entries plus beats in the pipeline reach 4.
// Reset (rst, synchronous): counters, window and queue cleared; registers 640, 480, 0.
// The line store RAM is not cleared.
module lbp_3x3_pixel_coder import lbp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               pixel_valid,
  output logic               pixel_ready,
  input  logic [PIX_W-1:0]   pixel,
  output logic               result_valid,
  input  logic               result_ready,
  output logic [PIX_W-1:0]   code,
  output logic               frame_last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [WIDTH_W-1:0]  image_width;
  logic [HEIGHT_W-1:0] image_height;
  logic                uniform_mode;

  logic [WIDTH_W-1:0]  w_eff;
  logic [HEIGHT_W-1:0] h_eff;

  logic [COL_W-1:0]    column_count;
  logic [HEIGHT_W-1:0] row_count;
  logic [COL_W-1:0]    column_count_next;
  logic [HEIGHT_W-1:0] row_count_next;

  logic [COL_W-1:0]    col_cur;
  logic [HEIGHT_W-1:0] row_cur;
  logic [HEIGHT_W:0]   row_pre;
  logic [WIDTH_W-1:0]  col_inc;
  logic [HEIGHT_W:0]   row_inc;

  logic                accept;
  logic                cfg_wr;

  logic [2*PIX_W-1:0]  line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0]  rd_data;

  s1_ctrl_t            s1;
  logic [COL_W-1:0]    s1_col;
  logic [PIX_W-1:0]    s1_pixel;

  logic                push;
  result_t             push_data;
  result_t             head;
  logic [OUT_CNT_W-1:0] q_count;
  logic [OUT_CNT_W:0]  in_flight;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_W'(640);
      image_height <= HEIGHT_W'(480);
      uniform_mode <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_IMAGE_WIDTH:  image_width  <= pwdata[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[HEIGHT_W-1:0];
        REG_UNIFORM_MODE: uniform_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_IMAGE_WIDTH:  prdata = PDATA_W'(image_width);
      REG_IMAGE_HEIGHT: prdata = PDATA_W'(image_height);
      REG_UNIFORM_MODE: prdata = PDATA_W'(uniform_mode);
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    if (image_width < WIDTH_W'(MIN_DIM))        w_eff = WIDTH_W'(MIN_DIM);
    else if (image_width > WIDTH_W'(MAX_WIDTH)) w_eff = WIDTH_W'(MAX_WIDTH);
    else                                        w_eff = image_width;
    h_eff = (image_height < HEIGHT_W'(MIN_DIM)) ? HEIGHT_W'(MIN_DIM) : image_height;
  end

  // raster position of the incoming beat and the position after it
  always_comb begin
    if (WIDTH_W'(column_count) >= w_eff) begin
      col_cur = '0;
      row_pre = {1'b0, row_count} + 1'b1;
    end else begin
      col_cur = column_count;
      row_pre = {1'b0, row_count};
    end
    row_cur = (row_pre >= {1'b0, h_eff}) ? '0 : row_pre[HEIGHT_W-1:0];

    col_inc = WIDTH_W'(col_cur) + 1'b1;
    row_inc = {1'b0, row_cur} + 1'b1;
    if (col_inc >= w_eff) begin
      column_count_next = '0;
      row_count_next    = (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[HEIGHT_W-1:0];
    end else begin
      column_count_next = col_inc[COL_W-1:0];
      row_count_next    = row_cur;
    end
  end

  // credit: queue entries plus beats still in the pipeline
  assign in_flight   = (OUT_CNT_W+1)'(q_count) + (OUT_CNT_W+1)'(s1.valid)
                     + (OUT_CNT_W+1)'(push);
  assign pixel_ready = in_flight < (OUT_CNT_W+1)'(OUT_DEPTH);
  assign accept      = pixel_valid && pixel_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      s1           <= '0;
    end else begin
      s1.valid <= accept;
      if (accept) begin
        column_count <= column_count_next;
        row_count    <= row_count_next;
        s1.emit      <= (row_cur >= HEIGHT_W'(2)) && (col_cur >= COL_W'(2));
        s1.last      <= (row_cur == h_eff - 1'b1) && (WIDTH_W'(col_cur) == w_eff - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col   <= col_cur;
      s1_pixel <= pixel;
    end
  end

  // line store: {upper, lower} per column; read on accept, written back in the following cycle
  always_ff @(posedge clk) begin
    if (accept) rd_data <= line_mem[col_cur];
  end

  always_ff @(posedge clk) begin
    if (s1.valid) line_mem[s1_col] <= {rd_data[PIX_W-1:0], s1_pixel};
  end

  lbp_code_unit u_code (
    .clk          (clk),
    .rst          (rst),
    .s1           (s1),
    .up           (rd_data[2*PIX_W-1:PIX_W]),
    .mid          (rd_data[PIX_W-1:0]),
    .pixel_d      (s1_pixel),
    .uniform_mode (uniform_mode),
    .push         (push),
    .push_data    (push_data)
  );

  lbp_out_fifo u_fifo (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .push_data    (push_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .head         (head),
    .count        (q_count)
  );

  assign code       = head.code;
  assign frame_last = head.frame_last;

  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    accept && s1.valid |-> col_cur != s1_col)
    else $error("line store read and write-back hit the same column");

  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    in_flight <= (OUT_CNT_W+1)'(OUT_DEPTH))
    else $error("more beats in flight than queue entries");

  a_col_advances: assert property (@(posedge clk) disable iff (rst)
    accept |=> column_count != $past(col_cur))
    else $error("column counter did not advance");

endmodule

// ----- src/lbp_code_unit.sv -----
// 3x3 window registers, neighbor compare and uniform remap stage.
// Depends on lbp_pkg.
module lbp_code_unit import lbp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  s1_ctrl_t         s1,
  input  logic [PIX_W-1:0] up,
  input  logic [PIX_W-1:0] mid,
  input  logic [PIX_W-1:0] pixel_d,
  input  logic             uniform_mode,
  output logic             push,
  output result_t          push_data
);

  logic [PIX_W-1:0] win [9];
  logic             s2_emit;
  logic             s2_last;
  logic [7:0]       pattern;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) win[i] <= '0;
      s2_emit <= 1'b0;
      s2_last <= 1'b0;
    end else begin
      s2_emit <= s1.valid && s1.emit;
      s2_last <= s1.last;
      if (s1.valid) begin
        win[0] <= win[1]; win[1] <= win[2]; win[2] <= up;
        win[3] <= win[4]; win[4] <= win[5]; win[5] <= mid;
        win[6] <= win[7]; win[7] <= win[8]; win[8] <= pixel_d;
      end
    end
  end

  // N, NE, E, SE, S, SW, W, NW, MSB first
  assign pattern = {win[1] > win[4], win[2] > win[4], win[5] > win[4], win[8] > win[4],
                    win[7] > win[4], win[6] > win[4], win[3] > win[4], win[0] > win[4]};

  assign push                 = s2_emit;
  assign push_data.code       = uniform_mode ? UNIFORM_LUT[pattern] : pattern;
  assign push_data.frame_last = s2_last;

  a_uniform_range: assert property (@(posedge clk) disable iff (rst)
    push && uniform_mode |-> push_data.code <= UNIFORM_MAX)
    else $error("uniform index out of range");

endmodule

// ----- src/lbp_out_fifo.sv -----
// Small result queue that decouples the output handshake from the pixel pipeline.
// Depends on lbp_pkg.
module lbp_out_fifo import lbp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  result_t              push_data,
  output logic                 result_valid,
  input  logic                 result_ready,
  output result_t              head,
  output logic [OUT_CNT_W-1:0] count
);

  result_t              mem [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr;
  logic [OUT_PTR_W-1:0] rd_ptr;
  logic                 pop;

  assign result_valid = count != '0;
  assign pop          = result_valid && result_ready;
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> count < OUT_CNT_W'(OUT_DEPTH))
    else $error("result queue overflow");

endmodule
